// ----- src/fir_convolution_filter_macros.svh -----
// Assertion macros shared by the FIR filter RTL.
`ifndef FIR_CONVOLUTION_FILTER_MACROS_SVH
`define FIR_CONVOLUTION_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during rst.
`define FCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked during rst.
`define FCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fcf_pkg.sv -----
// Shared constants, field layout and types for the FIR convolution filter.
`default_nettype none

package fcf_pkg;

  // fixed-point format
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int ACC_BITS    = 40;
  localparam int SAT_W       = ACC_BITS + 1 - FRAC_BITS;

  // default storage depth
  localparam int DEF_MAX_TAPS = 1024;

  // field widths
  localparam int OP_BITS        = 2;
  localparam int TAP_IDX_BITS   = 10;
  localparam int TAP_COUNT_BITS = 11;

  // s_tdata layout, lowest bit first
  localparam int SAMPLE_LSB  = 0;
  localparam int TAP_IDX_LSB = SAMPLE_LSB + SAMPLE_BITS;
  localparam int COEF_LSB    = TAP_IDX_LSB + TAP_IDX_BITS;
  localparam int IN_USED     = COEF_LSB + SAMPLE_BITS;
  localparam int IN_DATA_W   = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TAP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_REDUCE = 7'b0000010,
    ST_WRITE  = 7'b0000100,
    ST_MAC    = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_DONE   = 7'b0100000,
    ST_CLEAR  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- src/fir_convolution_filter.sv -----
// Direct-form FIR filter over a circular delay line held in block memory.
//
//  channel  | direction | payload (lowest bit up)                         | handshake
//  ---------+-----------+-------------------------------------------------+------------------
//  s_       | in        | tuser: op[1:0]                                  | s_tvalid/s_tready
//           |           | tdata: sample_in[15:0] tap_index[25:16]         |
//           |           |        coefficient[41:26], zeros to bit 47      |
//  m_       | out       | tdata: sample_out[15:0]                         | m_tvalid/m_tready
//  cfg_     | in        | data: tap_count[10:0]                           | cfg_valid/cfg_ready
//
// Sequence: a sample transfer (n = effective tap count) passes through reduce, write, the
//   single multiply-accumulate walking both memories one tap a cycle, drain and done,
//   where the result enters the output register; the next input is taken in the cycle
//   after. Reduce repeats a subtraction while the write position is not below a reduced
//   tap count. With n zero the sample goes straight to done and passes through unchanged.
//   Coefficient writes land at the transfer and unused ops are dropped, both in the idle
//   state.
// Reset (rst, synchronous) and the clear op start a sweep over all MAX_TAPS entries that
//   zeroes the delay line (and after reset the coefficients); no input is taken then.
// The result register lets a new item be accepted while the last result waits; a
//   finished result holds in the done state until the output register is free.
`default_nettype none

module fir_convolution_filter
  import fcf_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input stream
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  input  wire logic [IN_DATA_W-1:0]      s_tdata,   // sample_in, tap_index, coefficient
  input  wire logic [OP_BITS-1:0]        s_tuser,   // op
  // result stream
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [OUT_DATA_W-1:0]     m_tdata,   // sample_out
  // tap count register write
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [TAP_COUNT_BITS-1:0] cfg_data
);

  `include "fir_convolution_filter_macros.svh"

  localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam logic [ACC_BITS:0] ROUND_HALF =
    {{(ACC_BITS + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // storage
  logic signed [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_q;
  logic signed [SAMPLE_BITS-1:0] coef_q;

  // control
  state_t                        state;
  logic [TAP_COUNT_BITS-1:0]     tap_count;
  logic [ADDR_W-1:0]             wp;        // write position
  logic [ADDR_W-1:0]             k;         // coefficient address
  logic [ADDR_W-1:0]             j;         // delay-line address
  logic [ADDR_W-1:0]             clr_cnt;
  logic                          clr_coef;
  logic                          rd_v;
  logic                          prod_v;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [PROD_BITS-1:0]   prod;
  logic [ACC_BITS-1:0]           acc;

  // combinational
  logic [CNT_W-1:0]              n_taps;
  logic                          in_xfer;
  op_t                           in_op;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [TAP_IDX_BITS-1:0]       in_tap_idx;
  logic signed [SAMPLE_BITS-1:0] in_coef;
  logic                          dly_we;
  logic [ADDR_W-1:0]             dly_waddr;
  logic signed [SAMPLE_BITS-1:0] dly_wdata;
  logic                          coef_we;
  logic [ADDR_W-1:0]             coef_waddr;
  logic signed [SAMPLE_BITS-1:0] coef_wdata;
  logic                          k_last;
  logic                          j_wrap;
  logic [ACC_BITS:0]             rnd_sum;
  logic [SAT_W-1:0]              rnd_q;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic                          out_free;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ST_IDLE);
  assign in_xfer    = s_tvalid && s_tready;
  assign in_op      = op_t'(s_tuser);
  assign in_sample  = s_tdata[SAMPLE_LSB +: SAMPLE_BITS];
  assign in_tap_idx = s_tdata[TAP_IDX_LSB +: TAP_IDX_BITS];
  assign in_coef    = s_tdata[COEF_LSB +: SAMPLE_BITS];
  assign out_free   = !m_tvalid || m_tready;

  // tap count clipped to the storage depth
  always_comb begin
    if (int'(tap_count) > MAX_TAPS) begin
      n_taps = CNT_W'(MAX_TAPS);
    end else begin
      n_taps = CNT_W'(tap_count);
    end
  end

  assign k_last = (CNT_W'(k) + CNT_W'(1)) == n_taps;
  assign j_wrap = (CNT_W'(j) + CNT_W'(1)) == n_taps;

  // delay-line write: clear sweep or the new sample
  always_comb begin
    dly_we    = 1'b0;
    dly_waddr = wp;
    dly_wdata = x;
    if (state == ST_CLEAR) begin
      dly_we    = 1'b1;
      dly_waddr = clr_cnt;
      dly_wdata = '0;
    end else if (state == ST_WRITE) begin
      dly_we = 1'b1;
    end
  end

  // coefficient write: reset sweep or a tap transfer
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = ADDR_W'(in_tap_idx);
    coef_wdata = in_coef;
    if (state == ST_CLEAR) begin
      coef_we    = clr_coef;
      coef_waddr = clr_cnt;
      coef_wdata = '0;
    end else if (in_xfer && in_op == OP_TAP && int'(in_tap_idx) < MAX_TAPS) begin
      coef_we = 1'b1;
    end
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    dly_q <= dly_mem[j];
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_q <= coef_mem[k];
  end

  // round half up to Q1.15, then saturate
  assign rnd_sum = {acc[ACC_BITS-1], acc} + ROUND_HALF;
  assign rnd_q   = rnd_sum[ACC_BITS:FRAC_BITS];

  always_comb begin
    if (!rnd_q[SAT_W-1] && (|rnd_q[SAT_W-2:SAMPLE_BITS-1])) begin
      sat_val = SAT_MAX;
    end else if (rnd_q[SAT_W-1] && !(&rnd_q[SAT_W-2:SAMPLE_BITS-1])) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  // MAC datapath: product register, then accumulate
  always_ff @(posedge clk) begin
    prod <= coef_q * dly_q;
    if (state == ST_WRITE) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(ACC_BITS - PROD_BITS){prod[PROD_BITS-1]}}, prod};
    end
    if (in_xfer && in_op == OP_SAMPLE) begin
      x <= in_sample;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      tap_count <= '0;
      wp        <= '0;
      k         <= '0;
      j         <= '0;
      clr_cnt   <= '0;
      clr_coef  <= 1'b1;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
    end else begin
      rd_v   <= (state == ST_MAC);
      prod_v <= rd_v;

      if (cfg_valid && cfg_ready) begin
        tap_count <= cfg_data;
      end

      // output register: loaded from done, emptied by a transfer
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_op)
              OP_SAMPLE: begin
                state <= (n_taps == '0) ? ST_DONE : ST_REDUCE;
              end
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= ST_CLEAR;
              end
              OP_TAP, OP_NONE: begin
                // coefficient lands at the transfer; unused op dropped
              end
            endcase
          end
        end
        ST_REDUCE: begin
          // repeated subtraction: position modulo tap count
          if (CNT_W'(wp) >= n_taps) begin
            wp <= ADDR_W'(CNT_W'(wp) - n_taps);
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          k     <= '0;
          j     <= wp;
          state <= ST_MAC;
        end
        ST_MAC: begin
          k <= k + ADDR_W'(1);
          j <= j_wrap ? '0 : j + ADDR_W'(1);
          if (k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v && !prod_v) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (n_taps == '0) begin
              m_tdata <= OUT_DATA_W'($unsigned(x));
            end else begin
              m_tdata <= OUT_DATA_W'($unsigned(sat_val));
              wp      <= (wp == '0) ? ADDR_W'(n_taps - CNT_W'(1)) : wp - ADDR_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          wp      <= '0;
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(MAX_TAPS - 1)) begin
            clr_coef <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `FCF_ASSERT_NOW(a_mac_in_range, state == ST_MAC,
    (CNT_W'(k) < n_taps) && (CNT_W'(j) < n_taps), "MAC address beyond tap count")
  `FCF_ASSERT_NOW(a_write_pos_reduced, state == ST_WRITE,
    CNT_W'(wp) < n_taps, "write position not reduced before sample write")
  `FCF_ASSERT_NOW(a_done_drained, state == ST_DONE,
    !rd_v && !prod_v, "result taken while MAC pipeline busy")
  `FCF_ASSERT_NEXT(a_sweep_complete, state == ST_CLEAR && clr_cnt != ADDR_W'(MAX_TAPS - 1),
    state == ST_CLEAR, "clear sweep left early")
  `FCF_ASSERT_NEXT(a_result_hold, state == ST_DONE && !out_free,
    state == ST_DONE && m_tvalid, "finished result dropped while output busy")

endmodule

`default_nettype wire

// ----- verif/fir_convolution_filter_monitor.sv -----
// Checker for the FIR convolution filter: tracks filter state from the input and config transfers.
`timescale 1ns / 1ps

module fir_convolution_filter_monitor
  import fcf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  input  wire logic [IN_DATA_W-1:0]      s_tdata,   // sample_in, tap_index, coefficient
  input  wire logic [OP_BITS-1:0]        s_tuser,   // op
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic [OUT_DATA_W-1:0]     m_tdata,   // sample_out
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [TAP_COUNT_BITS-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int     TAP_LIMIT = DEF_MAX_TAPS;
  localparam longint SAT_HI    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO    = -SAT_HI - 1;
  localparam longint HALF_LSB  = longint'(1) <<< (FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0]    history [TAP_LIMIT];
  logic signed [SAMPLE_BITS-1:0]    coefs   [TAP_LIMIT];
  logic [TAP_IDX_BITS-1:0]          head;
  logic [TAP_COUNT_BITS-1:0]        taps_used;
  logic signed [SAMPLE_BITS-1:0]    pending_out [$];
  int                               fail_count = 0;

  // stores the sample, convolves, rounds half up, saturates, steps the head down; no taps passes x through
  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    int                  n;
    int                  p;
    int                  j;
    logic [ACC_BITS-1:0] acc;
    longint              total;
    n = (taps_used > TAP_LIMIT) ? TAP_LIMIT : int'(taps_used);
    if (n == 0) return x;
    p = int'(head) % n;
    history[p] = x;
    acc = '0;
    j = p;
    for (int k = 0; k < n; k++) begin
      acc = acc + ACC_BITS'(longint'(coefs[k]) * longint'(history[j]));
      j = (j + 1 == n) ? 0 : j + 1;
    end
    total = (longint'($signed(acc)) + HALF_LSB) >>> FRAC_BITS;
    if (total > SAT_HI) total = SAT_HI;
    if (total < SAT_LO) total = SAT_LO;
    head = TAP_IDX_BITS'((p + n - 1) % n);
    return SAMPLE_BITS'(total);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (history[i]) history[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      head = '0;
      taps_used = '0;
      pending_out.delete();
    end else begin
      if (cfg_valid && cfg_ready) taps_used = cfg_data;

      if (m_tvalid && m_tready) begin
        if (pending_out.size() == 0) begin
          $error("sample_out: unexpected transfer, expected none, got %0d",
                 $signed(m_tdata[SAMPLE_BITS-1:0]));
          fail_count++;
        end else if (m_tdata[SAMPLE_BITS-1:0] !== pending_out[0]) begin
          $error("sample_out: expected %0d, got %0d", pending_out[0],
                 $signed(m_tdata[SAMPLE_BITS-1:0]));
          fail_count++;
          void'(pending_out.pop_front());
        end else begin
          void'(pending_out.pop_front());
        end
      end

      if (s_tvalid && s_tready) begin
        case (op_t'(s_tuser))
          OP_SAMPLE: pending_out.push_back(filter_sample(s_tdata[SAMPLE_LSB +: SAMPLE_BITS]));
          OP_TAP:    coefs[s_tdata[TAP_IDX_LSB +: TAP_IDX_BITS]] = s_tdata[COEF_LSB +: SAMPLE_BITS];
          OP_CLEAR: begin
            foreach (history[i]) history[i] = '0;
            head = '0;
          end
          default: ;
        endcase
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_out.size();
  end

endmodule

// ----- verif/fir_convolution_filter_test.sv -----
// Testbench top for the FIR convolution filter: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module fir_convolution_filter_test;
  import fcf_pkg::*;

  localparam int TAP_LIMIT      = DEF_MAX_TAPS;
  // a clear sweep touches every delay line entry; leave room for it before a config write
  localparam int SETTLE_CYCLES  = DEF_MAX_TAPS + 64;
  // longest correct quiet stretch is the receiver hold-off or a settle pause, well under this
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 2000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // random phases: tap count in use, number of items, idling pattern
  localparam int PHASES      = 9;
  localparam int PAUSE_PHASE = 1;   // sender waits for every result halfway through
  localparam int HOLD_PHASE  = 7;   // receiver holds off long enough to back up the input
  int         phase_taps  [PHASES] = '{1, 7, 33, 5, 0, 1024, 2047, 16, 2};
  int         phase_items [PHASES] = '{60, 80, 80, 60, 30, 10, 8, 140, 80};
  idle_mode_t phase_idle  [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                       IDLE_RECEIVER, IDLE_NONE, IDLE_BOTH, IDLE_NONE,
                                       IDLE_SENDER};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_W-1:0]      s_tdata = '0;   // sample_in, tap_index, coefficient
  logic [OP_BITS-1:0]        s_tuser = '0;   // op
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]     m_tdata;        // sample_out
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [TAP_COUNT_BITS-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int gap_pct     = 0;   // chance per cycle that the sender sits idle
  int stall_pct   = 0;   // chance per cycle that the receiver stalls
  int hold_left   = 0;   // cycles left in a forced receiver hold-off
  int quiet_cycles = 0;

  fir_convolution_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  fir_convolution_filter_monitor i_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: a forced hold-off wins, otherwise random stalls at the phase rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, after a random idle gap, and hold it until the transfer.
  // Within this task tvalid is only lowered during a gap, so it gets one update per edge.
  task automatic send(input op_t op, input logic [SAMPLE_BITS-1:0] sample,
                      input logic [TAP_IDX_BITS-1:0] idx, input logic [SAMPLE_BITS-1:0] coef);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_DATA_W'({coef, idx, sample});
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait until the checker has seen every result it expects.
  // The first edge lets the count catch up with a transfer taken on this one.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Tap count only changes on an idle filter; clears and coefficient writes give no
  // result, so a clear sweep may still be running when the last result leaves.
  task automatic write_tap_count(input int value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= TAP_COUNT_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 66; stall_pct <= 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct <= 66; end
      IDLE_BOTH:     begin gap_pct = 19; stall_pct <= 19; end
      default:       begin gap_pct = 0;  stall_pct <= 0;  end
    endcase
  endtask

  // Q1.15 value biased towards full scale and small magnitudes.
  function automatic logic [SAMPLE_BITS-1:0] pick_q15();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_BITS'($urandom_range(255));
      3:       return -SAMPLE_BITS'($urandom_range(255));
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Mostly samples; coefficient writes mostly land inside the taps in use.
  task automatic send_random(input int taps);
    int pick;
    int span;
    pick = $urandom_range(99);
    span = (taps == 0 || taps > TAP_LIMIT) ? TAP_LIMIT : taps;
    if (pick < 72) begin
      send(OP_SAMPLE, pick_q15(), TAP_IDX_BITS'($urandom()), SAMPLE_BITS'($urandom()));
    end else if (pick < 92) begin
      send(OP_TAP, SAMPLE_BITS'($urandom()),
           ($urandom_range(3) == 0) ? TAP_IDX_BITS'($urandom())
                                    : TAP_IDX_BITS'($urandom_range(span - 1)),
           pick_q15());
    end else if (pick < 96) begin
      send(OP_CLEAR, SAMPLE_BITS'($urandom()), TAP_IDX_BITS'($urandom()),
           SAMPLE_BITS'($urandom()));
    end else begin
      send(OP_NONE, SAMPLE_BITS'($urandom()), TAP_IDX_BITS'($urandom()),
           SAMPLE_BITS'($urandom()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: pass-through at the reset tap count of zero, unused op, coefficient loads
    // including the top index.
    send(OP_SAMPLE, 16'h7FFF, '0, '0);
    send(OP_SAMPLE, 16'h8000, '0, '0);
    send(OP_NONE, 16'hFFFF, 10'h3FF, 16'hFFFF);
    send(OP_TAP, '0, 10'd0, 16'h7FFF);
    send(OP_TAP, '0, 10'd1, 16'h7FFF);
    send(OP_TAP, '0, 10'h3FF, 16'h8000);
    send(OP_TAP, '0, 10'd2, 16'h8000);

    // Three taps: build up into positive saturation, then swing to negative full scale.
    write_tap_count(3);
    send(OP_SAMPLE, 16'h7FFF, '0, '0);
    send(OP_SAMPLE, 16'h7FFF, '0, '0);
    send(OP_SAMPLE, 16'h7FFF, '0, '0);
    send(OP_SAMPLE, 16'h8000, '0, '0);
    send(OP_SAMPLE, 16'h8000, '0, '0);
    // clear empties the history but keeps the coefficients
    send(OP_CLEAR, '0, '0, '0);
    send(OP_SAMPLE, 16'd12345, '0, '0);

    // Single tap: rounding at exactly half an LSB both ways, and the one product
    // that overflows Q1.15 on its own.
    write_tap_count(1);
    send(OP_TAP, '0, 10'd0, 16'd1);
    send(OP_SAMPLE, 16'd16384, '0, '0);
    send(OP_SAMPLE, -16'sd16384, '0, '0);
    send(OP_SAMPLE, -16'sd16385, '0, '0);
    send(OP_TAP, '0, 10'd0, 16'h8000);
    send(OP_SAMPLE, 16'h8000, '0, '0);
    send(OP_SAMPLE, 16'h7FFF, '0, '0);

    // Random phases; the shrink from 33 to 5 taps leaves the write position out of range.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_tap_count(phase_taps[ph]);
      set_idling(phase_idle[ph]);
      if (ph == HOLD_PHASE) hold_left <= LONG_HOLD;
      for (int i = 0; i < phase_items[ph]; i++) begin
        if (ph == PAUSE_PHASE && i == phase_items[ph] / 2) wait_for_results();
        send_random(phase_taps[ph]);
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
